// ===== sv/bewe_pkg.sv =====
// Package of the bar element width encoder: payload types, states and the binomial table.
package bewe_pkg;

   // Binomial table covers C(a, b) for a in 0..31 and b in 0..7
   localparam int BinomRows = 32;
   localparam int BinomCols = 8;
   localparam int BinomW    = 22;

   typedef logic [BinomW-1:0] binom_tab_type [BinomRows*BinomCols];

   typedef struct packed {
      logic [21:0] value;
      logic [5:0]  modules;
      logic [3:0]  element_count;
      logic [4:0]  max_width;
      logic        no_narrow;
   } req_type;

   typedef struct packed {
      logic [5:0] width;
      logic [2:0] element_index;
      logic       last;
      logic       error;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOK,
      ST_EVAL,
      ST_LASTW,
      ST_RD,
      ST_LD,
      ST_WAIT
   } state_type;

   // Build Pascal's triangle at elaboration
   function automatic binom_tab_type build_binom();
      binom_tab_type t;
      for (int a = 0; a < BinomRows; a++) begin
         for (int b = 0; b < BinomCols; b++) begin
            if (b == 0)
               t[a*BinomCols+b] = BinomW'(1);
            else if (a == 0)
               t[a*BinomCols+b] = '0;
            else
               t[a*BinomCols+b] = t[(a-1)*BinomCols+b-1] + t[(a-1)*BinomCols+b];
         end
      end
      return t;
   endfunction

   localparam binom_tab_type BINOM_TAB = build_binom();

endpackage

// ===== sv/bewe_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bewe_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== sv/bar_element_width_encoder.sv =====
// Top level of the bar element width encoder.
// Usage: a request transfer on req_ carries a character value, the module
// count, the element count, the widest allowed element and the no-narrow
// flag. The block then finds the width of each element in turn and sends
// one rsp_ transfer per element, in order, with element_index, last on
// the final element and error when the value was out of range.
// Search: each candidate width of an element passes through ST_LOOK
// (binomial table lookup), then ST_EVAL (the subtract and compare). An
// element tries as many candidates as its final width, and the search
// covers all but the last element; the widths land in a small RAM
// and each is read back and offered through ST_RD, ST_LD and ST_WAIT,
// with ST_WAIT holding for receiver stalls.
// One request is handled at a time; req_ready is high only while idle.
// Reset clears the controller to idle and drops rsp_valid.
// A stalled receiver holds the result register until the transfer.
module bar_element_width_encoder #(
   parameter int MAX_ELEMENTS = 8,
   parameter int MAX_MODULES  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bewe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bewe_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAX_ELEMENTS);

   bewe_pkg::state_type state_ff, state_in;

   logic [3:0]         elems_ff;
   logic [5:0]         n_ff;
   logic [5:0]         w_ff;
   logic [2:0]         bar_ff;
   logic [4:0]         maxw_ff;
   logic               keep_ff;
   logic               narrow_ff;
   logic               err_ff;
   logic signed [31:0] val_ff;
   logic [bewe_pkg::BinomW-1:0] c1_ff, c2_ff, c3_ff;
   logic               rsp_valid_ff;
   bewe_pkg::rsp_type  rsp_ff;

   logic [3:0]         elems_sat;
   logic [5:0]         n_sat;
   logic [2:0]         rem;
   logic [5:0]         limit;
   logic signed [6:0]  a1, a2, a3;
   logic [7:0]         i1, i2, i3;
   logic signed [31:0] sub;
   logic signed [31:0] val_next;
   logic               found;
   logic               bar_done;
   logic               last_bar;

   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [5:0]         ram_wdata;
   logic [5:0]         ram_rdata;

   // Saturate the request into the legal range
   always_comb begin
      if (req_data.element_count < 4'd2)
         elems_sat = 4'd2;
      else if (req_data.element_count > 4'(MAX_ELEMENTS))
         elems_sat = 4'(MAX_ELEMENTS);
      else
         elems_sat = req_data.element_count;
      n_sat = (req_data.modules > 6'(MAX_MODULES)) ? 6'(MAX_MODULES) : req_data.modules;
      if (n_sat < {2'b00, elems_sat})
         n_sat = {2'b00, elems_sat};
   end

   // Table addresses for the three binomial terms of one candidate
   always_comb begin
      rem   = 3'(elems_ff - {1'b0, bar_ff} - 4'd1);
      limit = n_ff - {3'b000, rem};
      a1    = 7'(n_ff) - 7'(w_ff) - 7'sd1;
      a2    = 7'(n_ff) - 7'(w_ff) - 7'(rem) - 7'sd1;
      a3    = 7'(n_ff) - 7'(w_ff) - 7'(maxw_ff) - 7'sd1;
      i1    = {a1[4:0], 3'(rem - 3'd1)};
      i2    = {a2[4:0], 3'(rem - 3'd1)};
      i3    = {a3[4:0], 3'(rem - 3'd1)};
   end

   // Pattern count for this candidate and the trial subtraction
   always_comb begin
      sub = 32'(c1_ff);
      if (!keep_ff && !narrow_ff && w_ff != 6'd1)
         sub = sub - 32'(c2_ff);
      sub      = sub - 32'(c3_ff * 25'(rem));
      val_next = val_ff - sub;
      found    = val_next < 0;
      bar_done = found || (w_ff == limit);
      last_bar = ({1'b0, bar_ff} + 4'd1) == (elems_ff - 4'd1);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bewe_pkg::ST_IDLE:  if (req_valid) state_in = bewe_pkg::ST_LOOK;
         bewe_pkg::ST_LOOK:  state_in = bewe_pkg::ST_EVAL;
         bewe_pkg::ST_EVAL: begin
            if (bar_done && last_bar)
               state_in = bewe_pkg::ST_LASTW;
            else
               state_in = bewe_pkg::ST_LOOK;
         end
         bewe_pkg::ST_LASTW: state_in = bewe_pkg::ST_RD;
         bewe_pkg::ST_RD:    state_in = bewe_pkg::ST_LD;
         bewe_pkg::ST_LD:    state_in = bewe_pkg::ST_WAIT;
         bewe_pkg::ST_WAIT: begin
            if (rsp_ready)
               state_in = rsp_ff.last ? bewe_pkg::ST_IDLE : bewe_pkg::ST_RD;
         end
         default:            state_in = bewe_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the controller: RAM writes
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = bar_ff[AW-1:0];
      ram_wdata = w_ff;
      unique case (state_ff)
         bewe_pkg::ST_EVAL:  ram_we = bar_done;
         bewe_pkg::ST_LASTW: begin
            ram_we    = 1'b1;
            ram_wdata = n_ff;
         end
         default:            ram_we = 1'b0;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bewe_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == bewe_pkg::ST_LD)
            rsp_valid_ff <= 1'b1;
         else if (state_ff == bewe_pkg::ST_WAIT && rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath: load, search and read back
   always_ff @(posedge clock) begin
      c1_ff <= (a1 < 0) ? '0 : bewe_pkg::BINOM_TAB[i1];
      c2_ff <= (a2 < 0) ? '0 : bewe_pkg::BINOM_TAB[i2];
      c3_ff <= (a3 < 0) ? '0 : bewe_pkg::BINOM_TAB[i3];
      unique case (state_ff)
         bewe_pkg::ST_IDLE: begin
            elems_ff  <= elems_sat;
            n_ff      <= n_sat;
            w_ff      <= 6'd1;
            bar_ff    <= 3'd0;
            maxw_ff   <= req_data.max_width;
            keep_ff   <= req_data.no_narrow;
            narrow_ff <= 1'b0;
            err_ff    <= 1'b0;
            val_ff    <= 32'(req_data.value);
         end
         bewe_pkg::ST_EVAL: begin
            if (bar_done) begin
               n_ff      <= n_ff - w_ff;
               narrow_ff <= narrow_ff | (w_ff == 6'd1);
               err_ff    <= err_ff | !found;
               bar_ff    <= bar_ff + 3'd1;
               w_ff      <= 6'd1;
            end else begin
               val_ff <= val_next;
               w_ff   <= w_ff + 6'd1;
            end
         end
         bewe_pkg::ST_LASTW: bar_ff <= 3'd0;
         bewe_pkg::ST_LD: begin
            rsp_ff.width         <= ram_rdata;
            rsp_ff.element_index <= bar_ff;
            rsp_ff.last          <= ({1'b0, bar_ff} == (elems_ff - 4'd1));
            rsp_ff.error         <= err_ff;
         end
         bewe_pkg::ST_WAIT: if (rsp_ready) bar_ff <= bar_ff + 3'd1;
         default: begin
         end
      endcase
   end

   // Width store
   bewe_ram #(
      .WIDTH (6),
      .DEPTH (MAX_ELEMENTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (bar_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   assign req_ready = (state_ff == bewe_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== test/tb_top.sv =====
// Testbench of the bar element width encoder: directed table, random requests, scoreboard.
`timescale 1ns / 100ps

module tb_top;

   localparam int NumRandom = 345;

   typedef struct packed {
      bewe_pkg::req_type r;
      logic              typed;
      logic [3:0]        cnt;
      logic [7:0][5:0]   w;
      logic              err;
   } row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   bewe_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   bewe_pkg::rsp_type rsp_data;

   bewe_pkg::rsp_type pending_widths[$];
   logic [7:0][5:0] offer_w;
   int              offer_cnt;
   logic            offer_err;
   int              fail_count;
   int              rsp_seen;
   bit              stim_done;

   bar_element_width_encoder uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Directed rows; typed rows carry their expected widths
   row_type dir_rows[] = '{
      '{'{22'd0, 6'd2, 4'd2, 5'd31, 1'b1}, 1'b1, 4'd2, {36'd0, 6'd1, 6'd1}, 1'b0},
      '{'{22'd0, 6'd0, 4'd0, 5'd31, 1'b1}, 1'b1, 4'd2, {36'd0, 6'd1, 6'd1}, 1'b0},
      '{'{22'd0, 6'd4, 4'd2, 5'd0, 1'b1}, 1'b1, 4'd2, {36'd0, 6'd1, 6'd3}, 1'b1},
      '{'{22'd0, 6'd1, 4'd1, 5'd0, 1'b0}, 1'b1, 4'd2, {36'd0, 6'd1, 6'd1}, 1'b1},
      '{'{22'h3FFFFF, 6'd32, 4'd8, 5'd31, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'h3FFFFF, 6'd63, 4'd15, 5'd31, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd0, 6'd32, 4'd8, 5'd31, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd0, 6'd63, 4'd15, 5'd1, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd0, 6'd8, 4'd8, 5'd1, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd5, 6'd3, 4'd8, 5'd7, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd100, 6'd17, 4'd4, 5'd6, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd100, 6'd17, 4'd4, 5'd6, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd347, 6'd12, 4'd4, 5'd8, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd1000, 6'd15, 4'd4, 5'd7, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd2000, 6'd13, 4'd4, 5'd6, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd12345, 6'd26, 4'd8, 5'd9, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd54321, 6'd23, 4'd8, 5'd31, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'h2AAAAA, 6'd21, 4'd7, 5'd5, 1'b0}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'h155555, 6'd42, 4'd9, 5'd21, 1'b1}, 1'b0, 4'd0, '0, 1'b0},
      '{'{22'd1, 6'd32, 4'd2, 5'd16, 1'b0}, 1'b0, 4'd0, '0, 1'b0}
   };

   function automatic longint binom(longint n, longint k);
      longint acc;
      if (k < 0 || n < 0 || n < k)
         return 0;
      if (k > n - k)
         k = n - k;
      acc = 1;
      for (longint i = 1; i <= k; i++)
         acc = acc * (n - k + i) / i;
      return acc;
   endfunction

   // Walk the elements, subtracting pattern counts per candidate width
   function automatic void encode_widths(input bewe_pkg::req_type r,
                                         output logic [7:0][5:0] w,
                                         output int cnt, output logic err);
      longint val, n, elems, maxw, rem, lim, wd, sub, less;
      logic [7:0] narrow;
      bit found;
      int bar;
      val = r.value;
      n = r.modules;
      elems = r.element_count;
      maxw = r.max_width;
      narrow = '0;
      err = 1'b0;
      w = '0;
      if (elems < 2)
         elems = 2;
      if (elems > 8)
         elems = 8;
      if (n > 32)
         n = 32;
      if (n < elems)
         n = elems;
      for (bar = 0; bar < elems - 1; bar++) begin
         rem = elems - bar - 1;
         lim = n - rem;
         sub = 0;
         found = 0;
         for (wd = 1; wd <= lim; wd++) begin
            narrow[bar] = (wd == 1);
            sub = binom(n - wd - 1, rem - 1);
            if (!r.no_narrow && narrow == 0 && (n - wd - rem >= rem))
               sub -= binom(n - wd - (rem + 1), rem - 1);
            if (rem > 1) begin
               less = 0;
               for (longint m = n - wd - (rem - 1); m > maxw; m--)
                  less += binom(n - wd - m - 1, rem - 2);
               sub -= less * rem;
            end else if (n - wd > maxw) begin
               sub--;
            end
            val -= sub;
            if (val < 0) begin
               found = 1;
               break;
            end
         end
         if (!found) begin
            err = 1'b1;
            wd = lim;
         end
         val += sub;
         n -= wd;
         w[bar] = wd[5:0];
      end
      w[bar] = n[5:0];
      cnt = int'(elems);
   endfunction

   // Random request: mostly in range with varied value sizes, some raw noise
   function automatic bewe_pkg::req_type random_req();
      bewe_pkg::req_type r;
      logic [63:0] raw;
      if ($urandom_range(0, 9) == 0) begin
         raw = {$urandom, $urandom};
         r = raw[$bits(bewe_pkg::req_type)-1:0];
      end else begin
         r.value = 22'($urandom_range(0, (1 << $urandom_range(1, 22)) - 1));
         r.modules = 6'($urandom_range(2, 32));
         r.element_count = 4'($urandom_range(2, 8));
         r.max_width = 5'($urandom_range(1, 31));
         r.no_narrow = 1'($urandom_range(0, 1));
      end
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAIL bar_element_width_encoder");
      $finish;
   end

   // Offer one request; its expected widths change together with the payload
   task automatic send_request(input bewe_pkg::req_type r, input logic [7:0][5:0] ew,
                               input int ecnt, input logic eerr, input bit idle_ok);
      @(negedge clock);
      if (idle_ok && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      offer_w = ew;
      offer_cnt = ecnt;
      offer_err = eerr;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stimulus: reset, directed table, then random requests
   initial begin
      bewe_pkg::req_type r;
      logic [7:0][5:0]   ew;
      int                ecnt;
      logic              eerr;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      stim_done = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i]) begin
         r = dir_rows[i].r;
         if (dir_rows[i].typed) begin
            ew = dir_rows[i].w;
            ecnt = dir_rows[i].cnt;
            eerr = dir_rows[i].err;
         end else begin
            encode_widths(r, ew, ecnt, eerr);
         end
         send_request(r, ew, ecnt, eerr, 1'b1);
      end
      for (int i = 0; i < NumRandom; i++) begin
         r = random_req();
         encode_widths(r, ew, ecnt, eerr);
         send_request(r, ew, ecnt, eerr, !(i >= 100 && i < 160));
      end
      @(negedge clock);
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // Receiver: random stalls, one long hold-off, one stretch always ready
   initial begin
      int hold;
      rsp_ready = 1'b0;
      hold = 0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (rsp_seen >= 300 && hold < 3000) begin
            hold++;
            rsp_ready <= 1'b0;
         end else if (rsp_seen >= 600 && rsp_seen < 900) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 23);
         end
      end
   end

   // Queue expected widths on each request transfer, check each result transfer
   always @(posedge clock) begin
      bewe_pkg::rsp_type e;
      if (!reset && req_valid && req_ready) begin
         for (int k = 0; k < offer_cnt; k++) begin
            e.width = offer_w[k];
            e.element_index = k[2:0];
            e.last = (k == offer_cnt - 1);
            e.error = offer_err;
            pending_widths.push_back(e);
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen++;
         if (pending_widths.size() == 0) begin
            $display("%0t: unexpected result, got %p", $time, rsp_data);
            fail_count++;
         end else begin
            e = pending_widths.pop_front();
            if (rsp_data.width !== e.width || rsp_data.element_index !== e.element_index
                || rsp_data.last !== e.last || rsp_data.error !== e.error) begin
               $display("%0t: mismatch, expected %p, got %p", $time, e, rsp_data);
               fail_count++;
            end
         end
      end
   end

   // Drain, then give the verdict
   initial begin
      fail_count = 0;
      rsp_seen = 0;
      wait (stim_done);
      wait (pending_widths.size() == 0);
      repeat (600) @(posedge clock);
      if (fail_count == 0 && pending_widths.size() == 0)
         $display("PASS bar_element_width_encoder");
      else
         $display("FAIL bar_element_width_encoder");
      $finish;
   end

endmodule
